>>> rtl/utf16_to_utf8_encoder_macros.svh
// Assertion macros used by the UTF-16 to UTF-8 encoder back end
`ifndef UTF16_TO_UTF8_ENCODER_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define U16U8_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define U16U8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/u16u8_pkg.sv
// Package: command type, constants and UTF-8 byte helpers of the encoder
`default_nettype none

package u16u8_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned CAP_WIDTH       = 16;
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 16'd256;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  localparam logic [15:0] REPL_CHAR = 16'hFFFD;
  localparam logic [5:0]  HIGH_TAG  = 6'b110110;
  localparam logic [5:0]  LOW_TAG   = 6'b110111;
  localparam logic [20:0] PAIR_BASE = 21'h10000;

  localparam logic [20:0] CP_LIM1 = 21'h00080;
  localparam logic [20:0] CP_LIM2 = 21'h00800;
  localparam logic [20:0] CP_LIM3 = 21'h10000;

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;
  localparam logic [7:0] SIX_MASK = 8'h3F;

  // one accepted unit after surrogate pairing: up to two code points to encode
  typedef struct packed {
    logic        first;
    logic [1:0]  nseq;
    logic [20:0] cp_a;
    logic [15:0] cp_b;
  } u16u8_cmd_t;

  // sequence length minus one
  function automatic logic [1:0] u16u8_len_m1(input logic [20:0] cp);
    logic [1:0] l;
    if (cp < CP_LIM1) begin
      l = 2'd0;
    end else if (cp < CP_LIM2) begin
      l = 2'd1;
    end else if (cp < CP_LIM3) begin
      l = 2'd2;
    end else begin
      l = 2'd3;
    end
    return l;
  endfunction

  function automatic logic [7:0] u16u8_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                            input logic [1:0] idx);
    logic [1:0] pos;
    logic [7:0] six;
    logic [7:0] b;
    pos = len_m1 - idx;
    case (pos)
      2'd0:    six = {2'b00, cp[5:0]};
      2'd1:    six = {2'b00, cp[11:6]};
      2'd2:    six = {2'b00, cp[17:12]};
      default: six = {5'b00000, cp[20:18]};
    endcase
    six = six & SIX_MASK;
    if (idx == 2'd0) begin
      case (len_m1)
        2'd0:    b = cp[7:0];
        2'd1:    b = LEAD2 | six;
        2'd2:    b = LEAD3 | six;
        default: b = LEAD4 | six;
      endcase
    end else begin
      b = CONT | six;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/u16u8_front.sv
// Front end: accepts code units, pairs surrogates, pushes commands
`default_nettype none

module u16u8_front import u16u8_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] code_unit_i,
  input  wire logic        first_unit_i,
  input  wire logic        end_of_input_i,
  output logic             push_valid_o,
  input  wire logic        push_ready_i,
  output u16u8_cmd_t       cmd_o
);

  logic       pend_q, pend_d;
  logic [9:0] lead_q, lead_d;
  logic       pend, is_high, is_low, has_cur, accept;
  logic [15:0] cur_cp;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  always_comb begin
    is_high = (code_unit_i[15:10] == HIGH_TAG);
    is_low  = (code_unit_i[15:10] == LOW_TAG);
    pend    = first_unit_i ? 1'b0 : pend_q;
    pend_d  = 1'b0;
    lead_d  = lead_q;
    has_cur = 1'b1;
    cur_cp  = is_low ? REPL_CHAR : code_unit_i;
    if (is_high) begin
      cur_cp = REPL_CHAR;
      if (!end_of_input_i) begin
        // hold the lead until the next unit shows up
        has_cur = 1'b0;
        pend_d  = 1'b1;
        lead_d  = code_unit_i[9:0];
      end
    end

    cmd_o.first = first_unit_i;
    cmd_o.cp_b  = cur_cp;
    if (pend && is_low) begin
      cmd_o.nseq = 2'd1;
      cmd_o.cp_a = PAIR_BASE + {1'b0, lead_q, code_unit_i[9:0]};
      pend_d     = 1'b0;
      lead_d     = lead_q;
    end else if (pend) begin
      cmd_o.nseq = has_cur ? 2'd2 : 2'd1;
      cmd_o.cp_a = {5'b00000, REPL_CHAR};
    end else begin
      cmd_o.nseq = has_cur ? 2'd1 : 2'd0;
      cmd_o.cp_a = {5'b00000, cur_cp};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      lead_q <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      lead_q <= lead_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/u16u8_fifo.sv
// Command queue between front end and byte sequencer
`default_nettype none

module u16u8_fifo import u16u8_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_valid_i,
  output logic            push_ready_o,
  input  wire u16u8_cmd_t push_cmd_i,
  output logic            head_valid_o,
  output u16u8_cmd_t      head_cmd_o,
  input  wire logic       pop_i
);

  localparam int unsigned CNT_W = QPTR_W + 1;

  u16u8_cmd_t mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  fill_q;
  logic push, pop;

  assign push_ready_o = (fill_q != CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (fill_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/u16u8_back.sv
// Back end: capacity checks, one UTF-8 byte per cycle into a free output register
`default_nettype none

`include "utf16_to_utf8_encoder_macros.svh"

module u16u8_back import u16u8_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [COUNT_WIDTH-1:0] cap_i,
  input  wire logic                   head_valid_i,
  input  wire u16u8_cmd_t             head_cmd_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [7:0]                  out_byte_o,
  output logic                        byte_valid_o,
  output logic                        last_of_run_o,
  output logic                        done_res_o,
  output logic                        out_of_space_o,
  output logic [15:0]                 bytes_written_o
);

  logic [COUNT_WIDTH-1:0] count_q, count_d, cnt, new_cnt;
  logic                   done_q, done_d, dn;
  logic                   sel_q, sel_d;
  logic [1:0]             bidx_q, bidx_d;

  logic        out_valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        bval_q, bval_d, last_q, last_d, dres_q, dres_d, oos_q, oos_d;
  logic [15:0] wr_q, wr_d;

  logic        at_entry, clr, out_free, load, fits, room, last_byte, ends, seq_last;
  logic [20:0] cp;
  logic [1:0]  len_m1;
  logic [COUNT_WIDTH:0] sum;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    at_entry  = !sel_q && (bidx_q == 2'd0);
    clr       = at_entry && head_cmd_i.first;
    cnt       = clr ? '0 : count_q;
    dn        = clr ? 1'b0 : done_q;
    cp        = sel_q ? {5'b00000, head_cmd_i.cp_b} : head_cmd_i.cp_a;
    len_m1    = u16u8_len_m1(cp);
    sum       = {1'b0, cnt} + {{(COUNT_WIDTH-1){1'b0}}, len_m1} + (COUNT_WIDTH+1)'(1);
    fits      = (sum <= {1'b0, cap_i});
    room      = (cnt < cap_i);
    new_cnt   = cnt + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    last_byte = (bidx_q == len_m1);
    ends      = last_byte && ((cp == '0) || (new_cnt == cap_i));
    seq_last  = ends || (last_byte && !(!sel_q && (head_cmd_i.nseq == 2'd2)));

    pop_o   = 1'b0;
    load    = 1'b0;
    count_d = count_q;
    done_d  = done_q;
    sel_d   = sel_q;
    bidx_d  = bidx_q;
    byte_d  = '0;
    bval_d  = 1'b0;
    last_d  = 1'b1;
    dres_d  = 1'b1;
    oos_d   = 1'b0;
    wr_d    = 16'(cnt);

    if (head_valid_i) begin
      if (at_entry && dn) begin
        // string already ended: drop the unit
        pop_o = 1'b1;
      end else if (at_entry && !room) begin
        if (out_free) begin
          load    = 1'b1;
          count_d = cnt;
          done_d  = 1'b1;
          pop_o   = 1'b1;
        end
      end else if (head_cmd_i.nseq == 2'd0) begin
        pop_o   = 1'b1;
        count_d = cnt;
        done_d  = dn;
      end else if ((bidx_q == 2'd0) && !fits) begin
        if (out_free) begin
          load    = 1'b1;
          oos_d   = 1'b1;
          wr_d    = 16'(cap_i);
          count_d = cap_i;
          done_d  = 1'b1;
          pop_o   = 1'b1;
          sel_d   = 1'b0;
          bidx_d  = 2'd0;
        end
      end else if (out_free) begin
        load    = 1'b1;
        byte_d  = u16u8_byte(cp, len_m1, bidx_q);
        bval_d  = 1'b1;
        last_d  = seq_last;
        dres_d  = ends;
        wr_d    = 16'(new_cnt);
        count_d = new_cnt;
        done_d  = ends ? 1'b1 : dn;
        if (seq_last) begin
          pop_o  = 1'b1;
          sel_d  = 1'b0;
          bidx_d = 2'd0;
        end else if (last_byte) begin
          // advance to the unit that follows the flushed lead
          sel_d  = 1'b1;
          bidx_d = 2'd0;
        end else begin
          bidx_d = bidx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      done_q      <= 1'b0;
      sel_q       <= 1'b0;
      bidx_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
      sel_q   <= sel_d;
      bidx_q  <= bidx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      bval_q <= bval_d;
      last_q <= last_d;
      dres_q <= dres_d;
      oos_q  <= oos_d;
      wr_q   <= wr_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = byte_q;
  assign byte_valid_o    = bval_q;
  assign last_of_run_o   = last_q;
  assign done_res_o      = dres_q;
  assign out_of_space_o  = oos_q;
  assign bytes_written_o = wr_q;

  `U16U8_ASSERT_NOW(a_status_ends, clk_i, rst_ni, out_valid_q && !bval_q,
    dres_q && last_q, "status-only beat must end the string and the run")
  `U16U8_ASSERT_NOW(a_oos_status, clk_i, rst_ni, out_valid_q && oos_q,
    !bval_q && dres_q, "out-of-space beat must carry no byte")
  `U16U8_ASSERT_NOW(a_mid_seq_head, clk_i, rst_ni, sel_q || (bidx_q != 2'd0),
    head_valid_i, "command left the queue in the middle of a sequence")
  `U16U8_ASSERT_NOW(a_second_seq, clk_i, rst_ni, head_valid_i && sel_q,
    head_cmd_i.nseq == 2'd2, "second sequence selected on a one-sequence command")

endmodule

`default_nettype wire

>>> rtl/utf16_to_utf8_encoder.sv
// UTF-16 to UTF-8 encoder: one result beat per output byte or status.
// A unit is registered in the command queue and its beats in the output register.
// One beat per cycle while the output is taken; each unit is sequenced beat by beat,
// bounded by the single output register; a 4-entry queue decouples the front end.
// Reset: async active low; clears counts, held lead, queue; capacity returns to 256.
`default_nettype none

module utf16_to_utf8_encoder import u16u8_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CAP_WIDTH-1:0] cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [15:0]          code_unit_i,
  input  wire logic                 first_unit_i,
  input  wire logic                 end_of_input_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      byte_valid_o,
  output logic                      last_of_run_o,
  output logic                      done_res_o,
  output logic                      out_of_space_o,
  output logic [15:0]               bytes_written_o
);

  localparam logic [32:0] CNT_MAX_W = (33'd1 << COUNT_WIDTH) - 33'd1;
  localparam logic [COUNT_WIDTH-1:0] CAP_RST =
    (33'(CAP_RESET) > CNT_MAX_W) ? CNT_MAX_W[COUNT_WIDTH-1:0] : COUNT_WIDTH'(CAP_RESET);

  logic [COUNT_WIDTH-1:0] cap_q, cap_d;
  logic       push_valid, push_ready, pop, head_valid;
  u16u8_cmd_t push_cmd, head_cmd;

  // saturate capacity to what the counter can hold
  assign cap_d = (33'(cfg_wdata_i) > CNT_MAX_W) ? CNT_MAX_W[COUNT_WIDTH-1:0]
                                                : COUNT_WIDTH'(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RST;
    end else if (cfg_we_i) begin
      cap_q <= cap_d;
    end
  end

  u16u8_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .code_unit_i    (code_unit_i),
    .first_unit_i   (first_unit_i),
    .end_of_input_i (end_of_input_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .cmd_o          (push_cmd)
  );

  u16u8_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  u16u8_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cap_i           (cap_q),
    .head_valid_i    (head_valid),
    .head_cmd_i      (head_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .last_of_run_o   (last_of_run_o),
    .done_res_o      (done_res_o),
    .out_of_space_o  (out_of_space_o),
    .bytes_written_o (bytes_written_o)
  );

endmodule

`default_nettype wire
